### sv/tpm_pkg.sv
`default_nettype none

package tpm_pkg;

  localparam int unsigned CAM_BITS_DEF  = 10;
  localparam int unsigned DISP_BITS_DEF = 12;
  localparam int unsigned OUT_W         = 16;
  // quotient magnitude bits: one more than the output so clipping can be seen
  localparam int unsigned Q_BITS        = OUT_W + 1;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic [Q_BITS-1:0] POS_LIMIT = Q_BITS'((1 << (OUT_W - 1)) - 1);
  localparam logic [Q_BITS-1:0] NEG_LIMIT = Q_BITS'(1 << (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM0,
    REG_CAM1,
    REG_CAM2,
    REG_DISP0,
    REG_DISP1,
    REG_DISP2
  } cfg_reg_e;

  // control carried along the divider chain, lane 0 is x and lane 1 is y
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [1:0] neg;
    logic [1:0] ovf;
  } div_ctl_t;

endpackage

`default_nettype wire

### sv/tpm_in_if.sv
`default_nettype none

interface tpm_in_if #(
  parameter int unsigned CAM_COORD_BITS = tpm_pkg::CAM_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [CAM_COORD_BITS-1:0] cam_x;
  logic [CAM_COORD_BITS-1:0] cam_y;

  modport source (output valid, cam_x, cam_y, input ready);
  modport sink (input valid, cam_x, cam_y, output ready);
endinterface

`default_nettype wire

### sv/tpm_out_if.sv
`default_nettype none

interface tpm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tpm_pkg::OUT_W-1:0]  disp_x;
  logic signed [tpm_pkg::OUT_W-1:0]  disp_y;
  logic                              degenerate;
  logic                              saturated;

  modport source (output valid, disp_x, disp_y, degenerate, saturated, input ready);
  modport sink (input valid, disp_x, disp_y, degenerate, saturated, output ready);
endinterface

`default_nettype wire

### sv/three_point_affine_point_mapper_core.sv
// channel   dir  handshake      payload
// in_chan   in   valid/ready    cam_x, cam_y
// out_chan  out  valid/ready    disp_x, disp_y, degenerate, saturated
// cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// one point per cycle while the output is not stalled; from accept to result valid a point passes:
// 8 front stages with the first loaded at the accept edge, 17 divider cells, output register
// coefficients recompute continuously from the anchor registers through the tpm_coef stages
// reset clears the anchors and all valid bits
// a stalled output freezes the whole point pipeline; ready follows the output register
`default_nettype none

module three_point_affine_point_mapper_core #(
  parameter int unsigned CAM_COORD_BITS  = tpm_pkg::CAM_BITS_DEF,
  parameter int unsigned DISP_COORD_BITS = tpm_pkg::DISP_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [2*((CAM_COORD_BITS > DISP_COORD_BITS) ?
                 CAM_COORD_BITS : DISP_COORD_BITS)-1:0] cfg_wdata_i,
  tpm_in_if.sink                              in_chan,
  tpm_out_if.source                           out_chan
);

  import tpm_pkg::*;

  localparam int unsigned CB    = CAM_COORD_BITS;
  localparam int unsigned DB    = DISP_COORD_BITS;
  localparam int unsigned KW    = 2 * CB + 3;
  localparam int unsigned AW    = CB + DB + 3;
  localparam int unsigned CW    = 2 * CB + DB + 4;
  localparam int unsigned PW    = 2 * CB + DB + 4;
  localparam int unsigned NW    = PW + 2;
  localparam int unsigned HW    = NW - Q_BITS;
  localparam int unsigned DLY   = 4;

  logic [2:0][2*CB-1:0] cam_q;
  logic [2:0][2*DB-1:0] disp_q;

  logic [KW-1:0]          k_w;
  logic [1:0][AW-1:0]     a_w, b_w;
  logic [1:0][CW-1:0]     c_w;
  logic [KW-1:0]          kmag_q;

  logic adv;

  // front stages
  logic [DLY-1:0]  dv_q;
  logic [CB-1:0]   dx_q [DLY];
  logic [CB-1:0]   dy_q [DLY];
  logic            pv_q, sv_q, mv_q;
  logic signed [PW-1:0] pa_q [2];
  logic signed [PW-1:0] pb_q [2];
  logic signed [NW-1:0] num_q [2];
  logic [NW-1:0]   mag_q [2];
  logic [1:0]      neg_q;
  logic            degen_q;

  logic [HW-1:0]   hi [2];
  div_ctl_t        ctl_w [Q_BITS+1];
  logic [1:0][KW-1:0]     rem_w [Q_BITS+1];
  logic [1:0][Q_BITS-1:0] low_w [Q_BITS+1];
  logic [1:0][Q_BITS-1:0] q_w   [Q_BITS+1];
  div_ctl_t               ctl0_q;
  logic [1:0][KW-1:0]     rem0_q;
  logic [1:0][Q_BITS-1:0] low0_q;

  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  out_x_q, out_y_q;
  logic                     out_degen_q, out_sat_q;
  logic signed [OUT_W-1:0]  res [2];
  logic [1:0]               clip;
  div_ctl_t                 fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q  <= '0;
      disp_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CAM0:  cam_q[0]  <= cfg_wdata_i[2*CB-1:0];
        REG_CAM1:  cam_q[1]  <= cfg_wdata_i[2*CB-1:0];
        REG_CAM2:  cam_q[2]  <= cfg_wdata_i[2*CB-1:0];
        REG_DISP0: disp_q[0] <= cfg_wdata_i[2*DB-1:0];
        REG_DISP1: disp_q[1] <= cfg_wdata_i[2*DB-1:0];
        REG_DISP2: disp_q[2] <= cfg_wdata_i[2*DB-1:0];
        default: ;
      endcase
    end
  end

  tpm_coef #(
    .CAM_COORD_BITS (CB),
    .DISP_COORD_BITS(DB)
  ) u_coef (
    .clk_i (clk_i),
    .cam_i (cam_q),
    .disp_i(disp_q),
    .k_o   (k_w),
    .a_o   (a_w),
    .b_o   (b_w),
    .c_o   (c_w)
  );

  always_ff @(posedge clk_i) begin
    kmag_q <= k_w[KW-1] ? KW'(-$signed(k_w)) : k_w;
  end

  assign adv           = !out_valid_q || out_chan.ready;
  assign in_chan.ready = adv;

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= '0;
      pv_q   <= 1'b0;
      sv_q   <= 1'b0;
      mv_q   <= 1'b0;
      ctl0_q <= '0;
    end else if (adv) begin
      dv_q   <= {dv_q[DLY-2:0], in_chan.valid};
      pv_q   <= dv_q[DLY-1];
      sv_q   <= pv_q;
      mv_q   <= sv_q;
      ctl0_q.valid <= mv_q;
      ctl0_q.degen <= degen_q;
      ctl0_q.neg   <= neg_q;
      for (int l = 0; l < 2; l++) begin
        ctl0_q.ovf[l] <= {{KW{1'b0}}, hi[l]} >= {{HW{1'b0}}, kmag_q};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi[l] = mag_q[l][NW-1:Q_BITS];
    end
  end

  // delay line lets freshly written anchors reach the coefficient registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[0] <= in_chan.cam_x;
      dy_q[0] <= in_chan.cam_y;
      for (int i = 1; i < DLY; i++) begin
        dx_q[i] <= dx_q[i-1];
        dy_q[i] <= dy_q[i-1];
      end
      for (int l = 0; l < 2; l++) begin
        pa_q[l]  <= $signed(a_w[l]) * $signed({1'b0, dx_q[DLY-1]});
        pb_q[l]  <= $signed(b_w[l]) * $signed({1'b0, dy_q[DLY-1]});
        num_q[l] <= pa_q[l] + pb_q[l] + $signed(c_w[l]);
        mag_q[l] <= num_q[l][NW-1] ? NW'(-num_q[l]) : NW'(num_q[l]);
        neg_q[l] <= num_q[l][NW-1] ^ k_w[KW-1];
        rem0_q[l] <= KW'({{KW{1'b0}}, hi[l]});
        low0_q[l] <= mag_q[l][Q_BITS-1:0];
      end
      degen_q <= (k_w == '0);
    end
  end

  assign ctl_w[0] = ctl0_q;
  assign rem_w[0] = rem0_q;
  assign low_w[0] = low0_q;
  assign q_w[0]   = '0;

  for (genvar i = 0; i < Q_BITS; i++) begin : g_div
    tpm_div_cell #(
      .DW(KW),
      .QB(Q_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .div_i (kmag_q),
      .ctl_i (ctl_w[i]),
      .rem_i (rem_w[i]),
      .low_i (low_w[i]),
      .q_i   (q_w[i]),
      .ctl_o (ctl_w[i+1]),
      .rem_o (rem_w[i+1]),
      .low_o (low_w[i+1]),
      .q_o   (q_w[i+1])
    );
  end

  // sign, clipping and the collinear case
  always_comb begin
    fin = ctl_w[Q_BITS];
    for (int l = 0; l < 2; l++) begin
      clip[l] = fin.ovf[l] ||
                (fin.neg[l] ? (q_w[Q_BITS][l] > NEG_LIMIT) : (q_w[Q_BITS][l] > POS_LIMIT));
      if (fin.degen) begin
        res[l] = '0;
      end else if (clip[l]) begin
        res[l] = fin.neg[l] ? OUT_MIN : OUT_MAX;
      end else if (fin.neg[l]) begin
        res[l] = OUT_W'(~q_w[Q_BITS][l] + 1'b1);
      end else begin
        res[l] = OUT_W'(q_w[Q_BITS][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q     <= res[0];
      out_y_q     <= res[1];
      out_degen_q <= fin.degen;
      out_sat_q   <= !fin.degen && (clip[0] || clip[1]);
    end
  end

  assign out_chan.valid      = out_valid_q;
  assign out_chan.disp_x     = out_x_q;
  assign out_chan.disp_y     = out_y_q;
  assign out_chan.degenerate = out_degen_q;
  assign out_chan.saturated  = out_sat_q;

endmodule

`default_nettype wire

### sv/tpm_coef.sv
`default_nettype none

module tpm_coef #(
  parameter int unsigned CAM_COORD_BITS  = tpm_pkg::CAM_BITS_DEF,
  parameter int unsigned DISP_COORD_BITS = tpm_pkg::DISP_BITS_DEF
) (
  input  logic                                                  clk_i,
  input  logic [2:0][2*CAM_COORD_BITS-1:0]                      cam_i,
  input  logic [2:0][2*DISP_COORD_BITS-1:0]                     disp_i,
  output logic [2*CAM_COORD_BITS+2:0]                           k_o,
  output logic [1:0][CAM_COORD_BITS+DISP_COORD_BITS+2:0]       a_o,
  output logic [1:0][CAM_COORD_BITS+DISP_COORD_BITS+2:0]       b_o,
  output logic [1:0][2*CAM_COORD_BITS+DISP_COORD_BITS+3:0]     c_o
);

  localparam int unsigned CB = CAM_COORD_BITS;
  localparam int unsigned DB = DISP_COORD_BITS;
  localparam int unsigned KW = 2 * CB + 3;
  localparam int unsigned AW = CB + DB + 3;
  localparam int unsigned MW = CB + DB;
  localparam int unsigned CW = 2 * CB + DB + 4;

  logic [CB-1:0] xs [3];
  logic [CB-1:0] ys [3];
  logic [DB-1:0] xd [2][3];

  logic signed [CB:0] dxs02, dxs12, dys02, dys12;
  logic signed [DB:0] dd02 [2];
  logic signed [DB:0] dd12 [2];

  // stage 1: products of differences and cross products for the offset term
  logic signed [2*CB+1:0] pk0_q, pk1_q;
  logic signed [AW-2:0]   pa0_q [2];
  logic signed [AW-2:0]   pa1_q [2];
  logic signed [AW-2:0]   pb0_q [2];
  logic signed [AW-2:0]   pb1_q [2];
  logic [MW-1:0]          m_q   [2][6];
  logic [CB-1:0]          ys1_q [3];

  // stage 2
  logic signed [KW-1:0]   k_q;
  logic signed [AW-1:0]   a_q   [2];
  logic signed [AW-1:0]   b_q   [2];
  logic signed [MW:0]     cd_q  [2][3];
  logic [CB-1:0]          ys2_q [3];

  // stage 3 and 4
  logic signed [CW-3:0]   cp_q  [2][3];
  logic signed [CW-1:0]   c_q   [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = cam_i[i][CB-1:0];
      ys[i] = cam_i[i][2*CB-1:CB];
      xd[0][i] = disp_i[i][DB-1:0];
      xd[1][i] = disp_i[i][2*DB-1:DB];
    end
    dxs02 = $signed({1'b0, xs[0]}) - $signed({1'b0, xs[2]});
    dxs12 = $signed({1'b0, xs[1]}) - $signed({1'b0, xs[2]});
    dys02 = $signed({1'b0, ys[0]}) - $signed({1'b0, ys[2]});
    dys12 = $signed({1'b0, ys[1]}) - $signed({1'b0, ys[2]});
    for (int l = 0; l < 2; l++) begin
      dd02[l] = $signed({1'b0, xd[l][0]}) - $signed({1'b0, xd[l][2]});
      dd12[l] = $signed({1'b0, xd[l][1]}) - $signed({1'b0, xd[l][2]});
    end
  end

  always_ff @(posedge clk_i) begin
    pk0_q <= dxs02 * dys12;
    pk1_q <= dxs12 * dys02;
    for (int l = 0; l < 2; l++) begin
      pa0_q[l] <= dd02[l] * dys12;
      pa1_q[l] <= dd12[l] * dys02;
      pb0_q[l] <= dxs02 * dd12[l];
      pb1_q[l] <= dd02[l] * dxs12;
      m_q[l][0] <= xs[2] * xd[l][1];
      m_q[l][1] <= xs[1] * xd[l][2];
      m_q[l][2] <= xs[0] * xd[l][2];
      m_q[l][3] <= xs[2] * xd[l][0];
      m_q[l][4] <= xs[1] * xd[l][0];
      m_q[l][5] <= xs[0] * xd[l][1];
    end
    for (int i = 0; i < 3; i++) begin
      ys1_q[i] <= ys[i];
      ys2_q[i] <= ys1_q[i];
    end

    k_q <= pk0_q - pk1_q;
    for (int l = 0; l < 2; l++) begin
      a_q[l] <= pa0_q[l] - pa1_q[l];
      b_q[l] <= pb0_q[l] - pb1_q[l];
      for (int j = 0; j < 3; j++) begin
        cd_q[l][j] <= $signed({1'b0, m_q[l][2*j]}) - $signed({1'b0, m_q[l][2*j+1]});
        cp_q[l][j] <= $signed({1'b0, ys2_q[j]}) * cd_q[l][j];
      end
      c_q[l] <= cp_q[l][0] + cp_q[l][1] + cp_q[l][2];
    end
  end

  assign k_o = k_q;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_o[l] = a_q[l];
      b_o[l] = b_q[l];
      c_o[l] = c_q[l];
    end
  end

endmodule

`default_nettype wire

### sv/tpm_div_cell.sv
`default_nettype none

module tpm_div_cell #(
  parameter int unsigned DW = 2 * tpm_pkg::CAM_BITS_DEF + 3,
  parameter int unsigned QB = tpm_pkg::Q_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [DW-1:0]         div_i,
  input  tpm_pkg::div_ctl_t     ctl_i,
  input  logic [1:0][DW-1:0]    rem_i,
  input  logic [1:0][QB-1:0]    low_i,
  input  logic [1:0][QB-1:0]    q_i,
  output tpm_pkg::div_ctl_t     ctl_o,
  output logic [1:0][DW-1:0]    rem_o,
  output logic [1:0][QB-1:0]    low_o,
  output logic [1:0][QB-1:0]    q_o
);

  tpm_pkg::div_ctl_t ctl_q;
  logic [1:0][DW-1:0] rem_q;
  logic [1:0][QB-1:0] low_q, q_q;
  logic [DW:0] trial [2];
  logic [1:0]  fits;

  // one restoring step per lane: bring down the next dividend bit
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_i[l], low_i[l][QB-1]};
      fits[l]  = trial[l] >= {1'b0, div_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= fits[l] ? DW'(trial[l] - {1'b0, div_i}) : trial[l][DW-1:0];
        low_q[l] <= {low_i[l][QB-2:0], 1'b0};
        q_q[l]   <= {q_i[l][QB-2:0], fits[l]};
      end
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign low_o = low_q;
  assign q_o   = q_q;

endmodule

`default_nettype wire
